@@ rtl/core/first_fit_free_list_allocator_defines.svh @@
// assertion macros for the free list allocator
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFA_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFA_ASSERT_RST(lbl, clk, rst, prop, msg)
`define FFA_ASSERT(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/ffa_pkg.sv @@
// shared types and constants of the free list allocator
package ffa_pkg;
   localparam int TableEntriesDefault = 1024;
   localparam int CountOutWidth = 11;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_LOST  = 2'd2;

   typedef struct packed {
      logic        command;
      logic [31:0] block_addr;
      logic [31:0] block_size;
   } req_type;

   typedef struct packed {
      logic [31:0]              alloc_addr;
      logic [1:0]               status;
      logic [31:0]              free_total;
      logic [CountOutWidth-1:0] entry_count;
      logic [CountOutWidth-1:0] peak_entries;
      logic [31:0]              lost_count;
      logic [31:0]              lost_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } region_type;
endpackage

@@ rtl/core/ffa_if.sv @@
// valid/ready channels for requests and responses
interface ffa_req_if;
   import ffa_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ffa_rsp_if;
   import ffa_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/first_fit_free_list_allocator.sv @@
// first-fit free region allocator with coalescing, table held in one ram
// a request scans the table from entry 0, then shifts entries one at a time by a read then a write
// one request in flight; the next transfer is taken with the result transfer
// synchronous active-high reset clears counts and statistics, ram is not cleared
`include "first_fit_free_list_allocator_defines.svh"
module first_fit_free_list_allocator #(
   parameter int TABLE_ENTRIES = ffa_pkg::TableEntriesDefault
) (
   input logic clock,
   input logic reset,
   ffa_req_if.sink req_bus,
   ffa_rsp_if.source rsp_bus
);
   import ffa_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      IDLE, CHECK, DECIDE, SHIFT_DN, SHIFT_DN_WR, SHIFT_UP, SHIFT_UP_WR, FINISH
   } state_type;

   // region ram, start and length packed per entry
   region_type region_mem [TABLE_ENTRIES];
   region_type rd_data_ff;
   logic       mem_re, mem_we;
   logic [IW-1:0] mem_ra, mem_wa;
   region_type mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         region_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= region_mem[mem_ra];
      end
   end

   state_type  state_ff, state_in;
   logic       cmd_ff, cmd_in;
   logic [31:0] addr_ff, addr_in, size_ff, size_in;
   logic [CW-1:0] idx_ff, idx_in, k_ff, k_in;
   region_type prev_ff, prev_in, next_ff, next_in;
   logic       have_prev_ff, have_prev_in, have_next_ff, have_next_in;
   logic [CW-1:0] count_ff, count_in, peak_ff, peak_in;
   logic [31:0] sum_ff, sum_in, lost_cnt_ff, lost_cnt_in, lost_bytes_ff, lost_bytes_in;
   logic [1:0] status_ff, status_in;
   logic [31:0] res_addr_ff, res_addr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // working values of the current step
   logic [31:0] blk_end, prev_end, merged_len;
   logic [32:0] lost_sum;
   logic [CW-1:0] idx_next, p_idx;

   assign req_bus.ready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   assign blk_end  = addr_ff + size_ff;
   assign prev_end = prev_ff.start + prev_ff.length;
   assign idx_next = idx_ff + CW'(1);
   assign p_idx    = idx_ff - CW'(1);
   assign lost_sum = {1'b0, lost_bytes_ff} + {1'b0, size_ff};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      have_prev_in  = have_prev_ff;
      have_next_in  = have_next_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      sum_in        = sum_ff;
      lost_cnt_in   = lost_cnt_ff;
      lost_bytes_in = lost_bytes_ff;
      status_in     = status_ff;
      res_addr_in   = res_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      merged_len    = prev_ff.length + size_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_ra        = '0;
      mem_wa        = '0;
      mem_wd        = '0;
      case (state_ff)
         IDLE: begin
            if (req_bus.valid && req_bus.ready) begin
               cmd_in       = req_bus.data.command;
               addr_in      = req_bus.data.block_addr;
               size_in      = req_bus.data.block_size;
               idx_in       = '0;
               res_addr_in  = '0;
               status_in    = STATUS_DONE;
               have_prev_in = 1'b0;
               have_next_in = 1'b0;
               if (count_ff == '0) begin
                  if (req_bus.data.command == CMD_ALLOC) begin
                     status_in = STATUS_NOFIT;
                     state_in  = FINISH;
                  end else begin
                     state_in = DECIDE;
                  end
               end else begin
                  // read of entry 0 goes out with the transfer
                  mem_re   = 1'b1;
                  state_in = CHECK;
               end
            end
         end
         CHECK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (rd_data_ff.length >= size_ff) begin
                  res_addr_in = rd_data_ff.start;
                  sum_in      = sum_ff - size_ff;
                  if (rd_data_ff.length == size_ff) begin
                     state_in = SHIFT_DN;
                  end else begin
                     mem_we   = 1'b1;
                     mem_wa   = idx_ff[IW-1:0];
                     mem_wd   = '{start: rd_data_ff.start + size_ff,
                                  length: rd_data_ff.length - size_ff};
                     state_in = FINISH;
                  end
               end else if (idx_next == count_ff) begin
                  status_in = STATUS_NOFIT;
                  state_in  = FINISH;
               end else begin
                  mem_re = 1'b1;
                  mem_ra = idx_next[IW-1:0];
                  idx_in = idx_next;
               end
            end else begin
               // look for the first region above the freed block
               if (rd_data_ff.start > addr_ff) begin
                  next_in      = rd_data_ff;
                  have_next_in = 1'b1;
                  have_prev_in = (idx_ff != '0);
                  state_in     = DECIDE;
               end else begin
                  prev_in = rd_data_ff;
                  idx_in  = idx_next;
                  if (idx_next == count_ff) begin
                     have_prev_in = 1'b1;
                     have_next_in = 1'b0;
                     state_in     = DECIDE;
                  end else begin
                     mem_re = 1'b1;
                     mem_ra = idx_next[IW-1:0];
                  end
               end
            end
         end
         DECIDE: begin
            if (have_prev_ff && prev_end == addr_ff) begin
               // grow the region below, maybe absorbing the one above
               sum_in = sum_ff + size_ff;
               mem_we = 1'b1;
               mem_wa = p_idx[IW-1:0];
               if (have_next_ff && blk_end == next_ff.start) begin
                  merged_len = prev_ff.length + size_ff + next_ff.length;
                  state_in   = SHIFT_DN;
               end else begin
                  state_in = FINISH;
               end
               mem_wd = '{start: prev_ff.start, length: merged_len};
            end else if (have_next_ff && blk_end == next_ff.start) begin
               sum_in   = sum_ff + size_ff;
               mem_we   = 1'b1;
               mem_wa   = idx_ff[IW-1:0];
               mem_wd   = '{start: addr_ff, length: next_ff.length + size_ff};
               state_in = FINISH;
            end else if (count_ff < CW'(TABLE_ENTRIES)) begin
               k_in     = count_ff;
               state_in = SHIFT_UP;
            end else begin
               // table full, count the loss
               if (lost_cnt_ff != '1) begin
                  lost_cnt_in = lost_cnt_ff + 32'd1;
               end
               lost_bytes_in = lost_sum[32] ? '1 : lost_sum[31:0];
               status_in     = STATUS_LOST;
               state_in      = FINISH;
            end
         end
         SHIFT_DN: begin
            // remove entry idx by moving the rest down one place
            if (idx_next < count_ff) begin
               mem_re   = 1'b1;
               mem_ra   = idx_next[IW-1:0];
               state_in = SHIFT_DN_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = FINISH;
            end
         end
         SHIFT_DN_WR: begin
            mem_we   = 1'b1;
            mem_wa   = idx_ff[IW-1:0];
            mem_wd   = rd_data_ff;
            idx_in   = idx_next;
            state_in = SHIFT_DN;
         end
         SHIFT_UP: begin
            // open a hole at idx, top entry first
            if (k_ff > idx_ff) begin
               mem_re   = 1'b1;
               mem_ra   = IW'(k_ff - CW'(1));
               state_in = SHIFT_UP_WR;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = idx_ff[IW-1:0];
               mem_wd   = '{start: addr_ff, length: size_ff};
               count_in = count_ff + CW'(1);
               if (peak_ff < count_ff + CW'(1)) begin
                  peak_in = count_ff + CW'(1);
               end
               sum_in   = sum_ff + size_ff;
               state_in = FINISH;
            end
         end
         SHIFT_UP_WR: begin
            mem_we   = 1'b1;
            mem_wa   = k_ff[IW-1:0];
            mem_wd   = rd_data_ff;
            k_in     = k_ff - CW'(1);
            state_in = SHIFT_UP;
         end
         FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{alloc_addr: res_addr_ff, status: status_ff,
                             free_total: sum_ff,
                             entry_count: CountOutWidth'(count_ff),
                             peak_entries: CountOutWidth'(peak_ff),
                             lost_count: lost_cnt_ff, lost_bytes: lost_bytes_ff};
            state_in     = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         peak_ff       <= '0;
         sum_ff        <= '0;
         lost_cnt_ff   <= '0;
         lost_bytes_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         sum_ff        <= sum_in;
         lost_cnt_ff   <= lost_cnt_in;
         lost_bytes_ff <= lost_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      size_ff      <= size_in;
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      have_prev_ff <= have_prev_in;
      have_next_ff <= have_next_in;
      status_ff    <= status_in;
      res_addr_ff  <= res_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // checks
   `FFA_ASSERT_RST(a_count_bound, clock, reset, count_ff <= CW'(TABLE_ENTRIES), "count overflow")
   `FFA_ASSERT_RST(a_peak_ge_count, clock, reset, peak_ff >= count_ff, "peak below count")
   `FFA_ASSERT(a_no_write_idle, clock, (state_ff == IDLE) |-> !mem_we, "ram write while idle")
   `FFA_ASSERT_RST(a_slot_free, clock, reset, (req_bus.valid && req_bus.ready) |=> !rsp_valid_ff, "result slot busy after transfer")
endmodule

@@ tb/first_fit_free_list_allocator_tb.sv @@
// self-checking testbench for the first-fit free list allocator
module first_fit_free_list_allocator_tb;
   import ffa_pkg::*;

   localparam int Entries = TableEntriesDefault;
   localparam int HoldOff = 300;
   // allows for the worst scan plus shift, plus the long receiver hold-off
   localparam int IdleLimit = 4 * (2 * Entries + HoldOff);
   localparam int DrainCycles = 3 * Entries + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ffa_req_if req_ch ();
   ffa_rsp_if rsp_ch ();

   first_fit_free_list_allocator #(.TABLE_ENTRIES(Entries)) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mirror of the free region table, kept in address order
   logic [31:0] mirror_start [Entries];
   logic [31:0] mirror_length [Entries];
   int          mirror_count;
   int          mirror_peak;
   logic [31:0] mirror_free_sum;
   logic [31:0] mirror_lost_count;
   logic [31:0] mirror_lost_bytes;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      error_count = 0;
   int      idle_cycles = 0;
   int      send_gap = 0;
   int      hold_cycles = 0;
   bit      hold_done = 1'b0;

   // close the hole at index idx by pulling later entries down
   task automatic squeeze_out(input int idx);
      int k;
      mirror_count--;
      for (k = idx; k < mirror_count; k++) begin
         mirror_start[k] = mirror_start[k + 1];
         mirror_length[k] = mirror_length[k + 1];
      end
   endtask

   // apply one accepted request to the mirror and build the response it should give
   task automatic apply_request(input req_type r, output rsp_type e);
      int          k;
      int          pos;
      bit          merged;
      logic [31:0] fin;
      logic [31:0] got_addr;
      logic [1:0]  st;
      logic [32:0] wide_bytes;
      got_addr = '0;
      st = STATUS_DONE;
      merged = 1'b0;
      if (r.command == CMD_ALLOC) begin
         st = STATUS_NOFIT;
         // first fit: lowest address region that is large enough
         for (k = 0; k < mirror_count; k++) begin
            if (mirror_length[k] >= r.block_size) begin
               got_addr = mirror_start[k];
               mirror_start[k] = mirror_start[k] + r.block_size;
               mirror_length[k] = mirror_length[k] - r.block_size;
               mirror_free_sum = mirror_free_sum - r.block_size;
               if (mirror_length[k] == 0) squeeze_out(k);
               st = STATUS_DONE;
               break;
            end
         end
      end else begin
         fin = r.block_addr + r.block_size;
         for (pos = 0; pos < mirror_count; pos++) begin
            if (mirror_start[pos] > r.block_addr) break;
         end
         // coalesce with the region below, and possibly the one above as well
         if (pos > 0 && mirror_start[pos-1] + mirror_length[pos-1] == r.block_addr) begin
            mirror_length[pos-1] = mirror_length[pos-1] + r.block_size;
            mirror_free_sum = mirror_free_sum + r.block_size;
            if (pos < mirror_count && fin == mirror_start[pos]) begin
               mirror_length[pos-1] = mirror_length[pos-1] + mirror_length[pos];
               squeeze_out(pos);
            end
            merged = 1'b1;
         end
         // coalesce with the region above only
         if (!merged && pos < mirror_count && fin == mirror_start[pos]) begin
            mirror_start[pos] = r.block_addr;
            mirror_length[pos] = mirror_length[pos] + r.block_size;
            mirror_free_sum = mirror_free_sum + r.block_size;
            merged = 1'b1;
         end
         if (!merged && mirror_count < Entries) begin
            for (k = mirror_count; k > pos; k--) begin
               mirror_start[k] = mirror_start[k - 1];
               mirror_length[k] = mirror_length[k - 1];
            end
            mirror_count++;
            if (mirror_peak < mirror_count) mirror_peak = mirror_count;
            mirror_start[pos] = r.block_addr;
            mirror_length[pos] = r.block_size;
            mirror_free_sum = mirror_free_sum + r.block_size;
         end else if (!merged) begin
            // table full: the block is lost, statistics saturate
            st = STATUS_LOST;
            if (mirror_lost_count != 32'hFFFF_FFFF) mirror_lost_count++;
            wide_bytes = {1'b0, mirror_lost_bytes} + {1'b0, r.block_size};
            mirror_lost_bytes = wide_bytes[32] ? 32'hFFFF_FFFF : wide_bytes[31:0];
         end
      end
      e.alloc_addr = got_addr;
      e.status = st;
      e.free_total = mirror_free_sum;
      e.entry_count = mirror_count[CountOutWidth-1:0];
      e.peak_entries = mirror_peak[CountOutWidth-1:0];
      e.lost_count = mirror_lost_count;
      e.lost_bytes = mirror_lost_bytes;
   endtask

   task automatic push_req(input logic cmd, input logic [31:0] addr, input logic [31:0] size);
      req_type r;
      r.command = cmd;
      r.block_addr = addr;
      r.block_size = size;
      pending_reqs.push_back(r);
   endtask

   // mostly no gap at all, often short gaps, a few long ones
   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // request driver: the next transfer is offered once the previous one is taken
   always @(posedge clock) begin
      req_type nxt;
      rsp_type e;
      logic    drive_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else begin
         drive_valid = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            apply_request(req_ch.data, e);
            expected_rsps.push_back(e);
            drive_valid = 1'b0;
            send_gap = pick_gap();
         end
         if (!drive_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_ch.data <= nxt;
               drive_valid = 1'b1;
            end
         end
         req_ch.valid <= drive_valid;
      end
   end

   // response monitor and ready control, with one long hold-off early in the run
   always @(posedge clock) begin
      rsp_type e;
      rsp_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_rsps.size() == 0) begin
               $error("response transfer with nothing expected");
               error_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (got.alloc_addr !== e.alloc_addr) begin
                  $error("alloc_addr: expected %h, got %h", e.alloc_addr, got.alloc_addr);
                  error_count++;
               end
               if (got.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, got.status);
                  error_count++;
               end
               if (got.free_total !== e.free_total) begin
                  $error("free_total: expected %h, got %h", e.free_total, got.free_total);
                  error_count++;
               end
               if (got.entry_count !== e.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
                  error_count++;
               end
               if (got.peak_entries !== e.peak_entries) begin
                  $error("peak_entries: expected %0d, got %0d",
                         e.peak_entries, got.peak_entries);
                  error_count++;
               end
               if (got.lost_count !== e.lost_count) begin
                  $error("lost_count: expected %h, got %h", e.lost_count, got.lost_count);
                  error_count++;
               end
               if (got.lost_bytes !== e.lost_bytes) begin
                  $error("lost_bytes: expected %h, got %h", e.lost_bytes, got.lost_bytes);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (!hold_done && rsp_ch.valid) begin
            // long stall while the driver keeps offering requests
            hold_done = 1'b1;
            hold_cycles = HoldOff;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 40) == 0) begin
            hold_cycles = $urandom_range(10, 40);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else if (!reset) begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("first_fit_free_list_allocator test failed");
            $finish;
         end
      end
   end

   initial begin
      int k;
      logic [31:0] a;
      logic [31:0] s;
      mirror_count = 0;
      mirror_peak = 0;
      mirror_free_sum = '0;
      mirror_lost_count = '0;
      mirror_lost_bytes = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;

      // directed: empty table, merges both ways, zero sizes, wrapping sums
      push_req(CMD_ALLOC, 32'h0, 32'h10);
      push_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0);
      push_req(CMD_FREE, 32'h100, 32'h10);
      push_req(CMD_FREE, 32'h120, 32'h10);
      push_req(CMD_FREE, 32'h110, 32'h10);
      push_req(CMD_FREE, 32'h80, 32'h80);
      push_req(CMD_ALLOC, 32'h0, 32'h0);
      push_req(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF);
      push_req(CMD_ALLOC, 32'h0, 32'h40);
      push_req(CMD_FREE, 32'h0, 32'h0);
      push_req(CMD_ALLOC, 32'h0, 32'h0);
      push_req(CMD_FREE, 32'h500, 32'h0);
      push_req(CMD_FREE, 32'h500, 32'h8);
      push_req(CMD_FREE, 32'hFFFF_FFF0, 32'h20);
      push_req(CMD_FREE, 32'h4000_0000, 32'hF000_0000);
      push_req(CMD_ALLOC, 32'h0, 32'hE000_0000);
      push_req(CMD_ALLOC, 32'h0, 32'h1);
      push_req(CMD_FREE, 32'h0, 32'h80);
      push_req(CMD_ALLOC, 32'h0, 32'h7FFF_FFFF);

      // random: frees clustered so they coalesce, allocs carving them up
      for (k = 0; k < 271; k++) begin
         case ($urandom_range(0, 19))
            0: push_req(CMD_FREE, $urandom, $urandom);
            1: push_req(CMD_ALLOC, $urandom, $urandom);
            2, 3, 4, 5, 6, 7, 8, 9: begin
               s = $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : 32'd16;
               push_req(CMD_ALLOC, $urandom, s);
            end
            default: begin
               a = 32'h2000 + 16 * $urandom_range(0, 255);
               s = $urandom_range(0, 3) == 0 ? $urandom_range(0, 48) : 32'd16;
               push_req(CMD_FREE, a, s);
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("first_fit_free_list_allocator test passed");
      end else begin
         $display("first_fit_free_list_allocator test failed");
      end
      $finish;
   end
endmodule
